/* rtl/pfb_pkg.sv */
// ----------------------------------------------------------------------------
// Paged framebuffer blitter package
// Item types, mode codes and the control word of the byte merge unit.
// ----------------------------------------------------------------------------
package pfb_pkg;

	localparam logic [2:0] MODE_CLEAR     = 3'd0;
	localparam logic [2:0] MODE_PLOT      = 3'd1;
	localparam logic [2:0] MODE_BLIT_OR   = 3'd2;
	localparam logic [2:0] MODE_BLIT_MASK = 3'd3;
	localparam logic [2:0] MODE_READ      = 3'd4;

	localparam logic [7:0] BYTE_ONES = 8'hff;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] column;
		logic [7:0] row;
		logic [2:0] sprite_page;
		logic [7:0] sprite_bits;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       clipped;
	} rsp_t;

	typedef struct packed {
		logic       mask;
		logic       lo_half;
		logic [2:0] shift;
	} merge_ctl_t;

endpackage

/* rtl/pfb_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, either a write or a read with registered read data.
// ----------------------------------------------------------------------------
module pfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/pfb_merge.sv */
// ----------------------------------------------------------------------------
// Byte merge unit
// Shifts a sprite byte into place for the upper or lower page and merges it
// into a store byte in OR or AND-mask mode.
// ----------------------------------------------------------------------------
module pfb_merge (
	input  pfb_pkg::merge_ctl_t ctl,
	input  logic [7:0]          bits,
	input  logic [7:0]          old,
	output logic [7:0]          merged
);

	logic [3:0] lo_shift;
	logic [7:0] part;
	logic [7:0] keep;

	always_comb begin
		lo_shift = 4'd8 - {1'b0, ctl.shift};
		if (ctl.lo_half) begin
			part = bits >> lo_shift;
			keep = ~(pfb_pkg::BYTE_ONES >> lo_shift);
		end else begin
			part = bits << ctl.shift;
			keep = ~(pfb_pkg::BYTE_ONES << ctl.shift);
		end
		if (ctl.mask) begin
			merged = old & (part | keep);
		end else begin
			merged = old | part;
		end
	end

endmodule

/* rtl/page_framebuffer_blitter.sv */
// ----------------------------------------------------------------------------
// Paged monochrome framebuffer blitter
// Clears, plots, blits sprite bytes into and reads back a paged frame store.
// ----------------------------------------------------------------------------
// The frame store is one single-port RAM of SCREEN_COLUMNS * SCREEN_PAGES
// bytes. Every store byte a plot, read or blit touches is read, then written
// back through the shared merge unit unless the item is a read. Such an item
// passes ST_RD1 and ST_MOD1, a blit whose byte spans two on-screen pages also
// ST_RD2 and ST_MOD2, before ST_DONE registers its result; an item that
// touches nothing on screen goes straight to ST_DONE. The block takes the
// next item in the same cycle that the result is presented, and it waits in
// ST_DONE while the previous result is still stalled. A clear sweeps the
// store one byte a cycle, then goes to ST_DONE, and the same sweep runs after
// reset, during which no item is accepted.
module page_framebuffer_blitter #(
	parameter int SCREEN_COLUMNS = 128,
	parameter int SCREEN_PAGES   = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pfb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pfb_pkg::rsp_t rsp
);

	localparam int DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_RD1   = 7'b0000100,
		ST_MOD1  = 7'b0001000,
		ST_RD2   = 7'b0010000,
		ST_MOD2  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_cnt_q;
	logic                item_q;
	logic                do_lo_q;
	logic                rd_op_q;
	logic                clip_q;
	logic [7:0]          data_q;
	logic [7:0]          bits_q;
	logic [AW-1:0]       addr_hi_q;
	pfb_pkg::merge_ctl_t ctl_q;
	pfb_pkg::merge_ctl_t ctl;
	pfb_pkg::rsp_t       rsp_q;
	logic                rsp_valid_q;

	logic                accept;
	logic                col_ok;
	logic [5:0]          pg_base;
	logic [5:0]          pg_hi;
	logic [5:0]          pg_lo;
	logic                is_blit;
	logic                is_plot;
	logic                is_read;
	logic                hi_ok;
	logic                lo_need;
	logic                lo_ok;
	logic [14:0]         addr_full;

	logic                ram_en;
	logic                ram_we;
	logic [AW-1:0]       ram_addr;
	logic [7:0]          ram_wdata;
	logic [7:0]          ram_rdata;
	logic [7:0]          merged;

	assign accept = req_valid && (state_q == ST_IDLE);

	always_comb begin
		is_plot   = (req.mode == pfb_pkg::MODE_PLOT);
		is_read   = (req.mode == pfb_pkg::MODE_READ);
		is_blit   = req.mode inside {pfb_pkg::MODE_BLIT_OR, pfb_pkg::MODE_BLIT_MASK};
		col_ok    = {1'b0, req.column} < 9'(SCREEN_COLUMNS);
		pg_base   = {1'b0, req.row[7:3]};
		pg_hi     = is_blit ? (pg_base + {3'b000, req.sprite_page}) : pg_base;
		pg_lo     = pg_hi + 6'd1;
		hi_ok     = col_ok && (pg_hi < 6'(SCREEN_PAGES));
		lo_need   = is_blit && (req.row[2:0] != 3'd0);
		lo_ok     = col_ok && (pg_lo < 6'(SCREEN_PAGES));
		addr_full = 15'(pg_hi) * 15'(SCREEN_COLUMNS) + {7'b0, req.column};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			item_q    <= 1'b0;
			do_lo_q   <= 1'b0;
			rd_op_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						clr_cnt_q <= '0;
						state_q   <= item_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						item_q  <= 1'b1;
						rd_op_q <= is_read;
						do_lo_q <= lo_need && lo_ok;
						if (req.mode == pfb_pkg::MODE_CLEAR) begin
							state_q <= ST_CLEAR;
						end else if ((is_plot || is_read || is_blit) && hi_ok) begin
							state_q <= ST_RD1;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RD1: begin
					state_q <= ST_MOD1;
				end
				ST_MOD1: begin
					state_q <= do_lo_q ? ST_RD2 : ST_DONE;
				end
				ST_RD2: begin
					state_q <= ST_MOD2;
				end
				ST_MOD2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						item_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_hi_q     <= addr_full[AW-1:0];
			bits_q        <= is_plot ? 8'h01 : req.sprite_bits;
			ctl_q.mask    <= (req.mode == pfb_pkg::MODE_BLIT_MASK);
			ctl_q.lo_half <= 1'b0;
			ctl_q.shift   <= req.row[2:0];
			data_q        <= 8'h00;
			clip_q        <= (is_plot || is_read || is_blit) &&
			                 (!hi_ok || (lo_need && !lo_ok));
		end else if (state_q == ST_MOD1) begin
			ctl_q.lo_half <= 1'b1;
			if (rd_op_q) begin
				data_q <= ram_rdata;
			end
		end
	end

	always_comb begin
		ctl         = ctl_q;
		ram_en      = 1'b0;
		ram_we      = 1'b0;
		ram_addr    = addr_hi_q;
		ram_wdata   = merged;
		case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_cnt_q;
				ram_wdata = 8'h00;
			end
			ST_RD1: begin
				ram_en = 1'b1;
			end
			ST_MOD1: begin
				ram_en = !rd_op_q;
				ram_we = !rd_op_q;
			end
			ST_RD2: begin
				ram_en   = 1'b1;
				ram_addr = addr_hi_q + AW'(SCREEN_COLUMNS);
			end
			ST_MOD2: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = addr_hi_q + AW'(SCREEN_COLUMNS);
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	pfb_merge u_merge (
		.ctl    (ctl),
		.bits   (bits_q),
		.old    (ram_rdata),
		.merged (merged)
	);

	pfb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.read_data <= data_q;
			rsp_q.clipped   <= clip_q;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("Sequencer state is not one-hot.");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, ram_addr} < (AW+1)'(DEPTH)))
		else $error("Store write outside the frame store.");

	a_clear_writes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (ram_we && (ram_wdata == 8'h00)))
		else $error("Clear sweep did not write zero.");

	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_op_q && (state_q != ST_CLEAR)) |-> !ram_we)
		else $error("Read item wrote the store.");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("Result raised outside the done state.");

endmodule
